// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the rational arithmetic unit.
// Needs nothing else; files that assert take this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rational arithmetic unit check failed");

// Next-cycle implication, switched off while reset is asserted.
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rational arithmetic unit check failed");

`endif

// ----- rtl/rau_pkg.sv -----
// Package of the rational arithmetic unit: widths, opcodes and the
// request and response structs between the top level and the reducer.
// Depends on nothing; every other file but assert_macros.svh imports it.
`default_nettype none

package rau_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int OPC_W         = 4;
	// Operand width after sign extension, so that the most negative value can be negated.
	localparam int OPW1          = OPERAND_WIDTH + 1;
	localparam int PROD_W        = 2 * OPW1;
	localparam int SUM_W         = PROD_W + 1;
	// Magnitude of any numerator or denominator handed to the reducer.
	localparam int MAG_W         = 2 * OPERAND_WIDTH;
	localparam int RES_NUM_W     = 33;
	localparam int RES_DEN_W     = 32;
	localparam int EXT_W         = MAG_W + RES_NUM_W;
	localparam int DIV_CNT_W     = $clog2(MAG_W);
	localparam int MUL_CNT_W     = 2;

	localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(2);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MAG_W - 1);
	localparam logic signed [OPW1-1:0] ONE    = OPW1'(1);

	typedef enum logic [OPC_W-1:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_EQ  = 4'd4,
		OP_NE  = 4'd5,
		OP_LE  = 4'd6,
		OP_LT  = 4'd7,
		OP_GE  = 4'd8,
		OP_GT  = 4'd9,
		OP_RED = 4'd10
	} rau_op_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] num_mag;
		logic [MAG_W-1:0] den_mag;
	} red_req_t;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] num;
		logic [MAG_W-1:0] den;
	} red_rsp_t;

	function automatic logic is_cmp(input logic [OPC_W-1:0] op);
		return (op == OP_EQ) || (op == OP_NE) || (op == OP_LE) ||
			(op == OP_LT) || (op == OP_GE) || (op == OP_GT);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/rau_if.sv -----
// Valid/ready channel interfaces of the rational arithmetic unit, one for
// operand beats and one for result beats. Depends on rau_pkg.
`default_nettype none

interface rau_in_if import rau_pkg::*; ();
	logic                            valid;
	logic                            ready;
	logic [OPC_W-1:0]                opcode;
	logic signed [OPERAND_WIDTH-1:0] a_num;
	logic signed [OPERAND_WIDTH-1:0] a_den;
	logic signed [OPERAND_WIDTH-1:0] b_num;
	logic signed [OPERAND_WIDTH-1:0] b_den;

	modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
	modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if import rau_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [RES_NUM_W-1:0] res_num;
	logic [RES_DEN_W-1:0]        res_den;
	logic                        cmp_true;
	logic                        zero_den_error;

	modport source (output valid, res_num, res_den, cmp_true, zero_den_error, input ready);
	modport sink   (input valid, res_num, res_den, cmp_true, zero_den_error, output ready);
endinterface

`default_nettype wire

// ----- rtl/rau_reduce.sv -----
// Fraction reducer: binary gcd one step per cycle, then two exact restoring
// divisions by the gcd in parallel, one quotient bit per cycle. Depends on rau_pkg.
`default_nettype none

module rau_reduce import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  red_req_t req,
	output red_rsp_t rsp
);

	typedef enum logic [4:0] {
		R_IDLE = 5'b00001,
		R_TWOS = 5'b00010,
		R_GCD  = 5'b00100,
		R_DIV  = 5'b01000,
		R_DONE = 5'b10000
	} red_state_t;

	red_state_t state_q;

	logic [MAG_W-1:0]     nr_q, dr_q;
	logic [MAG_W-1:0]     u_q, v_q;
	logic [MAG_W-1:0]     remn_q, remd_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [MAG_W:0]   diff_uv;
	logic [MAG_W-1:0] diff_vu;
	logic             u_gt_v;
	logic             gcd_found;
	logic             twos_done;
	logic [MAG_W:0]   trial_n, trial_d, sub_n, sub_d;
	logic             fit_n, fit_d;

	// Both values odd and equal: that value is the odd part of the gcd.
	assign diff_uv   = {1'b0, u_q} - {1'b0, v_q};
	assign diff_vu   = v_q - u_q;
	assign u_gt_v    = !diff_uv[MAG_W] && (diff_uv != '0);
	assign gcd_found = u_q[0] && v_q[0] && (u_q == v_q);
	assign twos_done = nr_q[0] || dr_q[0];

	// nr_q and dr_q are shifted left as quotients form, exposing the next dividend bit.
	assign trial_n = {remn_q, nr_q[MAG_W-1]};
	assign trial_d = {remd_q, dr_q[MAG_W-1]};
	assign sub_n   = trial_n - {1'b0, u_q};
	assign sub_d   = trial_d - {1'b0, u_q};
	assign fit_n   = !sub_n[MAG_W];
	assign fit_d   = !sub_d[MAG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
		end else begin
			unique case (state_q)
				R_IDLE: begin
					if (req.start) begin
						state_q <= R_TWOS;
					end
				end
				R_TWOS: begin
					if (twos_done) begin
						state_q <= R_GCD;
					end
				end
				R_GCD: begin
					if (gcd_found) begin
						state_q <= R_DIV;
					end
				end
				R_DIV: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= R_DONE;
					end
				end
				R_DONE: begin
					state_q <= R_IDLE;
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			R_IDLE: begin
				if (req.start) begin
					nr_q <= req.num_mag;
					dr_q <= req.den_mag;
				end
			end
			R_TWOS: begin
				// Strip the common power of two from both values before the gcd.
				if (twos_done) begin
					u_q <= nr_q;
					v_q <= dr_q;
				end else begin
					nr_q <= {1'b0, nr_q[MAG_W-1:1]};
					dr_q <= {1'b0, dr_q[MAG_W-1:1]};
				end
			end
			R_GCD: begin
				if (!u_q[0]) begin
					u_q <= {1'b0, u_q[MAG_W-1:1]};
				end else if (!v_q[0]) begin
					v_q <= {1'b0, v_q[MAG_W-1:1]};
				end else if (gcd_found) begin
					remn_q <= '0;
					remd_q <= '0;
					cnt_q  <= '0;
				end else if (u_gt_v) begin
					u_q <= diff_uv[MAG_W:1];
				end else begin
					v_q <= {1'b0, diff_vu[MAG_W-1:1]};
				end
			end
			R_DIV: begin
				remn_q <= fit_n ? sub_n[MAG_W-1:0] : trial_n[MAG_W-1:0];
				remd_q <= fit_d ? sub_d[MAG_W-1:0] : trial_d[MAG_W-1:0];
				nr_q   <= {nr_q[MAG_W-2:0], fit_n};
				dr_q   <= {dr_q[MAG_W-2:0], fit_d};
				cnt_q  <= cnt_q + DIV_CNT_W'(1);
			end
			R_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = (state_q == R_DONE);
	assign rsp.num  = nr_q;
	assign rsp.den  = dr_q;

endmodule

`default_nettype wire

// ----- rtl/rational_arithmetic_unit.sv -----
// Rational arithmetic unit, top level: operand capture, one shared multiplier
// under a sequencer, sign handling and the result register. Depends on rau_pkg,
// rau_in_if, rau_out_if and rau_reduce.
//
// Usage: each beat on req carries an opcode and two fractions a_num/a_den and
// b_num/b_den. Each accepted beat gives exactly one beat on rsp. Add, subtract,
// multiply, divide and reduce-a return a fraction in lowest terms whose
// denominator is positive; a zero denominator returns 0/0 with zero_den_error
// set. The six comparisons return only cmp_true. Undefined opcodes return zeros.
// Timing: req.ready is high only while the sequencer is idle, so one item is in
// work at a time. The three products come from the one multiplier in turn.
// Comparisons and undefined opcodes skip the sign step and the reducer; zero
// results and zero denominators pass the sign step but skip the reducer.
// Other results go through the reducer: common factors of two are stripped,
// binary gcd steps follow at one per cycle, and the two divisions each form
// MAG_W quotient bits. The next beat can be taken once the finished result
// has moved into the output register.
// Reset clears the sequencers and drops rsp.valid. A stalled result waits in the
// output register while the next item is taken and worked on; that item holds
// in its last state until the output register is free.
`default_nettype none

module rational_arithmetic_unit import rau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rau_in_if.sink    req,
	rau_out_if.source rsp
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL  = 6'b000010,
		S_ADD  = 6'b000100,
		S_SGN  = 6'b001000,
		S_RED  = 6'b010000,
		S_FIN  = 6'b100000
	} top_state_t;

	top_state_t state_q;

	// Captured operands, widened by one bit. For comparisons each fraction is
	// already sign-normalized here so its denominator is not negative.
	rau_op_t                op_q;
	logic signed [OPW1-1:0] an_q, ad_q, bn_q, bd_q;
	logic [MUL_CNT_W-1:0]   mul_cnt_q;

	logic signed [OPW1-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] p0_q, p1_q, p2_q;

	logic signed [SUM_W-1:0]  sum_q;
	logic signed [PROD_W-1:0] den_q;
	logic                     neg_q;

	logic signed [RES_NUM_W-1:0] pend_num_q;
	logic [RES_DEN_W-1:0]        pend_den_q;
	logic                        pend_cmp_q;
	logic                        pend_err_q;

	logic                        rsp_valid_q;
	logic signed [RES_NUM_W-1:0] res_num_q;
	logic [RES_DEN_W-1:0]        res_den_q;
	logic                        cmp_true_q;
	logic                        zero_den_error_q;

	red_req_t         red_req;
	red_rsp_t         red_rsp;
	logic             red_start_q;
	logic [MAG_W-1:0] red_num_q, red_den_q;

	logic accept;
	logic out_free;
	logic in_cmp;
	logic cmp_res;
	logic op_arith;

	logic signed [OPW1-1:0] an_ext, ad_ext, bn_ext, bd_ext;
	logic [SUM_W-1:0]       num_abs;
	logic [PROD_W-1:0]      den_abs;
	logic [EXT_W-1:0]       n_ext, n_signed, d_ext;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign in_cmp   = is_cmp(req.opcode);

	assign an_ext = {req.a_num[OPERAND_WIDTH-1], req.a_num};
	assign ad_ext = {req.a_den[OPERAND_WIDTH-1], req.a_den};
	assign bn_ext = {req.b_num[OPERAND_WIDTH-1], req.b_num};
	assign bd_ext = {req.b_den[OPERAND_WIDTH-1], req.b_den};

	// Operands of the shared multiplier: product 0 feeds the first numerator term,
	// product 1 the second (add, sub, compares), product 2 the denominator.
	always_comb begin
		mul_a = an_q;
		mul_b = bd_q;
		unique case (op_q)
			OP_ADD, OP_SUB: begin
				unique case (mul_cnt_q)
					2'd0:    begin mul_a = bd_q; mul_b = an_q; end
					2'd1:    begin mul_a = bn_q; mul_b = ad_q; end
					default: begin mul_a = ad_q; mul_b = bd_q; end
				endcase
			end
			OP_MUL: begin
				if (mul_cnt_q == '0) begin
					mul_a = an_q;
					mul_b = bn_q;
				end else begin
					mul_a = ad_q;
					mul_b = bd_q;
				end
			end
			OP_DIV: begin
				if (mul_cnt_q == '0) begin
					mul_a = bd_q;
					mul_b = an_q;
				end else begin
					mul_a = bn_q;
					mul_b = ad_q;
				end
			end
			OP_EQ, OP_NE, OP_LE, OP_LT, OP_GE, OP_GT: begin
				if (mul_cnt_q == '0) begin
					mul_a = an_q;
					mul_b = bd_q;
				end else begin
					mul_a = bn_q;
					mul_b = ad_q;
				end
			end
			OP_RED: begin
				mul_a = (mul_cnt_q == '0) ? an_q : ad_q;
				mul_b = ONE;
			end
			default: begin
				mul_a = an_q;
				mul_b = bd_q;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		unique case (op_q)
			OP_EQ:   cmp_res = (p0_q == p1_q);
			OP_NE:   cmp_res = (p0_q != p1_q);
			OP_LE:   cmp_res = (p0_q <= p1_q);
			OP_LT:   cmp_res = (p0_q <  p1_q);
			OP_GE:   cmp_res = (p0_q >= p1_q);
			OP_GT:   cmp_res = (p0_q >  p1_q);
			default: cmp_res = 1'b0;
		endcase
	end

	assign op_arith = (op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_MUL) ||
		(op_q == OP_DIV) || (op_q == OP_RED);

	assign num_abs = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign den_abs = den_q[PROD_W-1] ? -den_q : den_q;

	// The reduced magnitudes are widened, the numerator is signed, and both are cut to the field widths.
	assign n_ext    = {{(EXT_W-MAG_W){1'b0}}, red_rsp.num};
	assign n_signed = neg_q ? -n_ext : n_ext;
	assign d_ext    = {{(EXT_W-MAG_W){1'b0}}, red_rsp.den};

	assign red_req = '{start: red_start_q, num_mag: red_num_q, den_mag: red_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			red_start_q <= 1'b0;
		end else begin
			// A result beat stays up until taken; a finished item raises it again.
			rsp_valid_q <= ((state_q == S_FIN) && out_free) || (rsp_valid_q && !rsp.ready);
			// The reducer is started for one cycle when a nonzero fraction needs reducing.
			red_start_q <= (state_q == S_SGN) && (den_q != '0) && (sum_q != '0);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_cnt_q == MUL_LAST) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					state_q <= op_arith ? S_SGN : S_FIN;
				end
				S_SGN: begin
					if ((den_q == '0) || (sum_q == '0)) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_RED;
					end
				end
				S_RED: begin
					if (red_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q      <= rau_op_t'(req.opcode);
					mul_cnt_q <= '0;
					an_q      <= (in_cmp && ad_ext[OPW1-1]) ? -an_ext : an_ext;
					ad_q      <= (in_cmp && ad_ext[OPW1-1]) ? -ad_ext : ad_ext;
					bn_q      <= (in_cmp && bd_ext[OPW1-1]) ? -bn_ext : bn_ext;
					bd_q      <= (in_cmp && bd_ext[OPW1-1]) ? -bd_ext : bd_ext;
				end
			end
			S_MUL: begin
				unique case (mul_cnt_q)
					2'd0:    p0_q <= mul_p;
					2'd1:    p1_q <= mul_p;
					default: p2_q <= mul_p;
				endcase
				mul_cnt_q <= mul_cnt_q + MUL_CNT_W'(1);
			end
			S_ADD: begin
				unique case (op_q)
					OP_ADD:  sum_q <= {p0_q[PROD_W-1], p0_q} + {p1_q[PROD_W-1], p1_q};
					OP_SUB:  sum_q <= {p0_q[PROD_W-1], p0_q} - {p1_q[PROD_W-1], p1_q};
					default: sum_q <= {p0_q[PROD_W-1], p0_q};
				endcase
				den_q      <= p2_q;
				pend_num_q <= '0;
				pend_den_q <= '0;
				pend_cmp_q <= cmp_res;
				pend_err_q <= 1'b0;
			end
			S_SGN: begin
				if (den_q == '0) begin
					pend_err_q <= 1'b1;
				end else if (sum_q == '0) begin
					pend_den_q <= RES_DEN_W'(1);
				end
				red_num_q <= num_abs[MAG_W-1:0];
				red_den_q <= den_abs[MAG_W-1:0];
				neg_q     <= sum_q[SUM_W-1] ^ den_q[PROD_W-1];
			end
			S_RED: begin
				if (red_rsp.done) begin
					pend_num_q <= n_signed[RES_NUM_W-1:0];
					pend_den_q <= d_ext[RES_DEN_W-1:0];
				end
			end
			S_FIN: begin
				if (out_free) begin
					res_num_q        <= pend_num_q;
					res_den_q        <= pend_den_q;
					cmp_true_q       <= pend_cmp_q;
					zero_den_error_q <= pend_err_q;
				end
			end
			default: begin
			end
		endcase
	end

	rau_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (red_req),
		.rsp    (red_rsp)
	);

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = rsp_valid_q;
	assign rsp.res_num        = res_num_q;
	assign rsp.res_den        = res_den_q;
	assign rsp.cmp_true       = cmp_true_q;
	assign rsp.zero_den_error = zero_den_error_q;

endmodule

`default_nettype wire

// ----- rtl/rau_checker.sv -----
// Port-level checks of the rational arithmetic unit and the bind that attaches
// them. Depends on rau_pkg, assert_macros.svh and rational_arithmetic_unit.
`default_nettype none
`include "assert_macros.svh"

module rau_checker import rau_pkg::*; (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_ready,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic signed [RES_NUM_W-1:0] res_num,
	input wire logic [RES_DEN_W-1:0]        res_den,
	input wire logic                        cmp_true,
	input wire logic                        zero_den_error
);

	// A stalled result beat keeps its payload.
	`RAU_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(res_num) && $stable(res_den) && $stable(cmp_true) && $stable(zero_den_error))

	// Only one item is in work: the block is busy right after taking a beat.
	`RAU_ASSERT_NXT(a_busy_after_take, clk, arst_n, req_valid && req_ready, !req_ready)

	// A zero denominator result is reported as 0/0 with no comparison outcome.
	`RAU_ASSERT_IMP(a_err_is_zero, clk, arst_n, rsp_valid && zero_den_error, res_num == '0 && res_den == '0 && !cmp_true)

	// A zero numerator with a valid denominator is always given as 0/1.
	`RAU_ASSERT_IMP(a_zero_is_unit, clk, arst_n, rsp_valid && res_num == '0 && res_den != '0, res_den == RES_DEN_W'(1) && !cmp_true)

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.res_num        (rsp.res_num),
	.res_den        (rsp.res_den),
	.cmp_true       (rsp.cmp_true),
	.zero_den_error (rsp.zero_den_error)
);

`default_nettype wire
